// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the scan multiplexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: property failed");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ----- rtl/lcsm_pkg.sv -----
// Types and constants of the LED cube scan multiplexer.
package lcsm_pkg;

    localparam int FRAME_W     = 27;
    localparam int REP_W       = 16;
    localparam int DWELL_W     = 16;
    localparam int PASS_W      = 15;
    localparam int LAYER_W     = 2;
    localparam int COL_W       = 4;
    localparam int LAYER_DRV_W = 3;
    localparam int COL_DRV_W   = 9;
    localparam int SCALE_W     = 5;
    localparam int DIV_CNT_W   = 4;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd100;
    localparam logic [SCALE_W-1:0] LOW_COUNT   = 5'd4;
    localparam logic [SCALE_W-1:0] COUNT_BIAS  = 5'd3;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [FRAME_W-1:0]   img;
        logic [REP_W-1:0]     rep;
        logic [SCALE_W-1:0]   scale;
    } lcsm_item_t;

    typedef struct packed {
        logic                   done;
        logic                   busy;
        logic [COL_DRV_W-1:0]   column_drive;
        logic [LAYER_DRV_W-1:0] layer_drive;
    } lcsm_result_t;

    typedef enum logic [2:0] {
        ST_FETCH = 3'b001,
        ST_DIV   = 3'b010,
        ST_FIN   = 3'b100
    } lcsm_state_t;

endpackage

// ----- rtl/lcsm_queue.sv -----
// Two-entry item queue between the front and back parts.
`include "assert_macros.svh"

module lcsm_queue
    import lcsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  lcsm_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       pop_valid,
    output lcsm_item_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lcsm_item_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_PROP(a_no_push_full, clk, rst_n, !(push && full && !pop))
    `ASSERT_PROP(a_no_pop_empty, clk, rst_n, !(pop && !pop_valid))
    `ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ----- rtl/lcsm_front.sv -----
// Front part: takes input items, masks the frame and works out the pass scale.
module lcsm_front
    import lcsm_pkg::*;
#(
    parameter int LAYER_COUNT  = 3,
    parameter int COLUMN_COUNT = 9
)
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 q_full,
    output logic                 q_push,
    output lcsm_item_t           q_item
);

    localparam int CELL_RAW   = LAYER_COUNT * COLUMN_COUNT;
    localparam int CELL_COUNT = (CELL_RAW < FRAME_W) ? CELL_RAW : FRAME_W;
    localparam logic [FRAME_W-1:0] SCAN_MASK = FRAME_W'((64'd1 << CELL_COUNT) - 64'd1);

    logic [FRAME_W-1:0] img;
    logic [SCALE_W-1:0] set_cnt;

    assign img     = s_tdata[FRAME_W-1:0] & SCAN_MASK;
    assign set_cnt = SCALE_W'($countones(img));

    always_comb
    begin
        q_item       = '0;
        q_item.cmd   = s_tuser;
        q_item.img   = img;
        q_item.rep   = s_tdata[FRAME_W+REP_W-1:FRAME_W];
        q_item.scale = (set_cnt < LOW_COUNT) ? set_cnt + COUNT_BIAS : set_cnt;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

// ----- rtl/lcsm_back.sv -----
// Back part: pass-count divider, scan sequencer and output register.
`include "assert_macros.svh"

module lcsm_back
    import lcsm_pkg::*;
#(
    parameter int LAYER_COUNT  = 3,
    parameter int COLUMN_COUNT = 9
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [DWELL_W-1:0] cfg_data,
    input  logic               q_valid,
    input  lcsm_item_t         q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output lcsm_result_t       m_result
);

    localparam int CELL_RAW   = LAYER_COUNT * COLUMN_COUNT;
    localparam int CELL_COUNT = (CELL_RAW < FRAME_W) ? CELL_RAW : FRAME_W;
    localparam int IDX_W      = $clog2(CELL_COUNT + 1);

    lcsm_state_t          state_reg, state_next;
    logic [DWELL_W-1:0]   dwell_ticks_reg, dwell_ticks_next;
    logic [FRAME_W-1:0]   img_reg, img_next;
    logic [PASS_W-1:0]    passes_reg, passes_next;
    logic [LAYER_W-1:0]   layer_reg, layer_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [DWELL_W-1:0]   dwell_cnt_reg, dwell_cnt_next;
    logic                 active_reg, active_next;
    logic                 out_valid_reg, out_valid_next;
    lcsm_result_t         out_reg, out_next;
    logic [SCALE_W-1:0]   scale_reg, scale_next;
    logic [SCALE_W-1:0]   rem_reg, rem_next;
    logic [REP_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic                 nx_found;
    logic [IDX_W-1:0]     nx_idx, first_idx;
    logic [LAYER_W-1:0]   nx_layer, first_layer;
    logic [COL_W-1:0]     nx_col, first_col;
    logic [SCALE_W:0]     trial;
    logic [DWELL_W-1:0]   limit, cnt_inc;
    logic [PASS_W-1:0]    passes_dec, div_passes;
    logic                 slot_free;

    assign m_tvalid  = out_valid_reg;
    assign m_result  = out_reg;
    assign slot_free = !out_valid_reg || m_tready;

    // next set cell after the current one, and first set cell of the frame
    always_comb
    begin
        nx_found    = 1'b0;
        nx_idx      = '0;
        nx_layer    = '0;
        nx_col      = '0;
        first_idx   = '0;
        first_layer = '0;
        first_col   = '0;
        for (int i = CELL_COUNT - 1; i >= 0; i--)
        begin
            if (img_reg[i] && (IDX_W'(i) > idx_reg))
            begin
                nx_found = 1'b1;
                nx_idx   = IDX_W'(i);
                nx_layer = LAYER_W'(i / COLUMN_COUNT);
                nx_col   = COL_W'(i % COLUMN_COUNT);
            end
            if (img_reg[i])
            begin
                first_idx   = IDX_W'(i);
                first_layer = LAYER_W'(i / COLUMN_COUNT);
                first_col   = COL_W'(i % COLUMN_COUNT);
            end
        end
    end

    assign trial      = {rem_reg, quo_reg[REP_W-1]};
    assign limit      = (dwell_ticks_reg == '0) ? DWELL_W'(1) : dwell_ticks_reg;
    assign cnt_inc    = dwell_cnt_reg + 1'b1;
    assign passes_dec = passes_reg - 1'b1;
    assign div_passes = quo_reg[PASS_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        dwell_ticks_next = dwell_ticks_reg;
        img_next         = img_reg;
        passes_next      = passes_reg;
        layer_next       = layer_reg;
        col_next         = col_reg;
        idx_next         = idx_reg;
        dwell_cnt_next   = dwell_cnt_reg;
        active_next      = active_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_next         = out_reg;
        scale_next       = scale_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        div_cnt_next     = div_cnt_reg;
        q_pop            = 1'b0;

        if (cfg_valid)
        begin
            dwell_ticks_next = cfg_data;
        end

        unique case (state_reg)
            ST_FETCH:
            begin
                priority if (q_valid && q_item.cmd == CMD_START)
                begin
                    q_pop        = 1'b1;
                    img_next     = q_item.img;
                    active_next  = 1'b0;
                    scale_next   = q_item.scale;
                    rem_next     = '0;
                    quo_next     = q_item.rep;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
                else if (q_valid && slot_free)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    if (active_reg)
                    begin
                        if (layer_reg < LAYER_W'(LAYER_DRV_W))
                        begin
                            out_next.layer_drive = LAYER_DRV_W'(1) << layer_reg;
                        end
                        if (col_reg < COL_W'(COL_DRV_W))
                        begin
                            out_next.column_drive = COL_DRV_W'(1) << col_reg;
                        end
                        if (cnt_inc >= limit)
                        begin
                            dwell_cnt_next = '0;
                            if (nx_found)
                            begin
                                idx_next   = nx_idx;
                                layer_next = nx_layer;
                                col_next   = nx_col;
                            end
                            else
                            begin
                                passes_next = passes_dec;
                                if (passes_dec == '0)
                                begin
                                    active_next   = 1'b0;
                                    idx_next      = '0;
                                    layer_next    = '0;
                                    col_next      = '0;
                                    out_next.done = 1'b1;
                                end
                                else
                                begin
                                    idx_next   = first_idx;
                                    layer_next = first_layer;
                                    col_next   = first_col;
                                end
                            end
                        end
                        else
                        begin
                            dwell_cnt_next = cnt_inc;
                        end
                    end
                    out_next.busy = active_next;
                end
                else
                begin
                    q_pop = 1'b0;
                end
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, scale_reg})
                begin
                    rem_next = SCALE_W'(trial - {1'b0, scale_reg});
                end
                else
                begin
                    rem_next = trial[SCALE_W-1:0];
                end
                quo_next     = {quo_reg[REP_W-2:0], (trial >= {1'b0, scale_reg})};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(REP_W - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    dwell_cnt_next = '0;
                    if (img_reg == '0 || div_passes == '0)
                    begin
                        active_next   = 1'b0;
                        passes_next   = '0;
                        idx_next      = '0;
                        layer_next    = '0;
                        col_next      = '0;
                        out_next.done = 1'b1;
                    end
                    else
                    begin
                        active_next   = 1'b1;
                        passes_next   = div_passes;
                        idx_next      = first_idx;
                        layer_next    = first_layer;
                        col_next      = first_col;
                        out_next.busy = 1'b1;
                    end
                    state_next = ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_FETCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_FETCH;
            dwell_ticks_reg <= DWELL_RESET;
            img_reg         <= '0;
            passes_reg      <= '0;
            layer_reg       <= '0;
            col_reg         <= '0;
            idx_reg         <= '0;
            dwell_cnt_reg   <= '0;
            active_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            dwell_ticks_reg <= dwell_ticks_next;
            img_reg         <= img_next;
            passes_reg      <= passes_next;
            layer_reg       <= layer_next;
            col_reg         <= col_next;
            idx_reg         <= idx_next;
            dwell_cnt_reg   <= dwell_cnt_next;
            active_reg      <= active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        scale_reg   <= scale_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        div_cnt_reg <= div_cnt_next;
    end

    `ASSERT_PROP(a_state_onehot, clk, rst_n, $onehot(state_reg))
    `ASSERT_PROP(a_active_has_passes, clk, rst_n, !active_reg || (passes_reg != '0 && img_reg != '0))
    `ASSERT_PROP(a_done_not_busy, clk, rst_n, !(out_valid_reg && out_reg.done && out_reg.busy))

endmodule

// ----- rtl/led_cube_scan_multiplexer_top.sv -----
// Top level of the LED cube scan multiplexer.
// Usage:
//   s_* carries one item per handshake: s_tuser is the command (0 tick,
//   1 start), s_tdata the frame image and raw repeat count of a start.
//   m_* returns exactly one result item per input item: layer and column
//   one-hot drives, busy and done flags.
//   cfg_* writes dwell_ticks; cfg_ready is always high. Write only while idle.
// Flow:
//   A tick is handled by the back sequencer; its result is registered and appears the
//   cycle after it leaves the two-entry queue.
//   A start runs a 16-step restoring divider (one quotient bit per cycle),
//   then its result is registered; the back sequencer takes 1 item per cycle
//   for ticks while the output slot is free, and pops no item during a start.
// Reset: rst_n clears the scan state to idle, dwell_ticks to 100, and
//   empties the queue and output register.
// Stall: with m_tready low the result is held in the output register; the
//   queue keeps taking items until full, then s_tready drops.
module led_cube_scan_multiplexer_top
    import lcsm_pkg::*;
#(
    parameter int LAYER_COUNT  = 3,
    parameter int COLUMN_COUNT = 9
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,   // command
    input  logic [S_TDATA_W-1:0] s_tdata,   // frame[26:0], repeat_req[42:27]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // layer_drive[2:0], column_drive[11:3],
                                            // busy_res[12], done_res[13]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [DWELL_W-1:0]   cfg_data   // dwell_ticks
);

    logic         q_full;
    logic         q_push;
    lcsm_item_t   q_in_item;
    logic         q_pop;
    logic         q_valid;
    lcsm_item_t   q_out_item;
    lcsm_result_t result;

    assign cfg_ready = 1'b1;
    assign m_tdata   = M_TDATA_W'(result);

    lcsm_front #(
        .LAYER_COUNT  (LAYER_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in_item)
    );

    lcsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_out_item)
    );

    lcsm_back #(
        .LAYER_COUNT  (LAYER_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_out_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

endmodule

// ----- dv/tb_led_cube_scan_multiplexer_top.sv -----
// Testbench for the LED cube scan multiplexer: directed and random item streams.
module tb_led_cube_scan_multiplexer_top;
    import lcsm_pkg::*;

    localparam int LAYERS        = 3;
    localparam int COLUMNS       = 9;
    localparam int CELLS         = 27;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASE_ITEMS   = 145;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic                 s_tuser;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [DWELL_W-1:0]   cfg_data;

    // scan model state
    logic [DWELL_W-1:0] dwell_cfg;
    logic [FRAME_W-1:0] lit_image;
    logic [PASS_W-1:0]  passes_rem;
    logic [LAYER_W-1:0] scan_layer;
    logic [COL_W-1:0]   scan_col;
    logic [DWELL_W-1:0] dwell_spent;
    bit                 scanning;

    lcsm_result_t expected_drive_q[$];
    int           mismatches;
    int           items_sent;
    bit           quiet;

    led_cube_scan_multiplexer_top #(
        .LAYER_COUNT  (LAYERS),
        .COLUMN_COUNT (COLUMNS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int first_lit(logic [FRAME_W-1:0] img, int from);
        for (int i = from; i < CELLS; i++)
            if (img[i])
                return i;
        return CELLS;
    endfunction

    function automatic void park_scan(int idx);
        scan_layer  = LAYER_W'(idx / COLUMNS);
        scan_col    = COL_W'(idx % COLUMNS);
        dwell_spent = '0;
    endfunction

    function automatic void stop_scan();
        scanning   = 1'b0;
        passes_rem = '0;
        park_scan(0);
    endfunction

    function automatic lcsm_result_t predict_scan(logic cmd, logic [FRAME_W-1:0] img,
                                                  logic [REP_W-1:0] rep);
        lcsm_result_t r;
        int           scale;
        int           passes;
        int           lim;
        int           nx;
        r = '0;
        if (cmd == CMD_START)
        begin
            scale = $countones(img);
            if (scale < 4)
                scale += 3;
            passes     = (rep / scale) & 32'h7FFF;
            lit_image  = img;
            passes_rem = PASS_W'(passes);
            if (img == '0 || passes == 0)
            begin
                stop_scan();
                r.done = 1'b1;
            end
            else
            begin
                scanning = 1'b1;
                park_scan(first_lit(img, 0));
            end
        end
        else if (scanning)
        begin
            lim = (dwell_cfg == '0) ? 1 : dwell_cfg;
            if (scan_layer < LAYERS)
                r.layer_drive = LAYER_DRV_W'(1) << scan_layer;
            if (scan_col < COLUMNS)
                r.column_drive = COL_DRV_W'(1) << scan_col;
            dwell_spent = dwell_spent + 1'b1;
            if (dwell_spent >= lim)
            begin
                nx = first_lit(lit_image, scan_layer * COLUMNS + scan_col + 1);
                if (nx < CELLS)
                    park_scan(nx);
                else
                begin
                    passes_rem = passes_rem - 1'b1;
                    nx = first_lit(lit_image, 0);
                    if (passes_rem == '0 || nx >= CELLS)
                    begin
                        stop_scan();
                        r.done = 1'b1;
                    end
                    else
                        park_scan(nx);
                end
            end
        end
        r.busy = scanning;
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic send_item(logic cmd, logic [FRAME_W-1:0] img, logic [REP_W-1:0] rep);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W-FRAME_W-REP_W){1'b0}}, rep, img};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_drive_q.push_back(predict_scan(cmd, img, rep));
        items_sent++;
    endtask

    task automatic send_start(logic [FRAME_W-1:0] img, logic [REP_W-1:0] rep);
        send_item(CMD_START, img, rep);
    endtask

    // tick items carry random, ignored payload
    task automatic send_ticks(int n);
        repeat (n) send_item(CMD_TICK, FRAME_W'($urandom), REP_W'($urandom));
    endtask

    task automatic wait_results(int settle);
        s_tvalid <= 1'b0;
        while (expected_drive_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_dwell(logic [DWELL_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        dwell_cfg = v;
    endtask

    task automatic test_idle_ticks();
        send_ticks(4);
        wait_results(SETTLE_CYCLES);
    endtask

    task automatic test_reset_dwell();
        send_start(27'h0000010, 16'd7);
        send_ticks(101);
        wait_results(SETTLE_CYCLES);
    endtask

    task automatic test_start_cases();
        write_dwell(16'd1);
        send_start('0, 16'hFFFF);
        send_start(27'h7FFFFFF, 16'd0);
        send_start(27'h4000000, 16'd3);
        send_start(27'h4000000, 16'd8);
        send_ticks(3);
        wait_results(0);
        send_start(27'h7FFFFFF, 16'hFFFF);
        send_ticks(5);
        send_start(27'h0000201, 16'd5);
        send_ticks(2);
        send_start(27'h000000F, 16'd4);
        send_ticks(5);
        wait_results(SETTLE_CYCLES);
    endtask

    task automatic test_dwell_extremes();
        write_dwell(16'd0);
        send_start(27'h0000007, 16'd6);
        send_ticks(4);
        wait_results(SETTLE_CYCLES);
        write_dwell(16'hFFFF);
        send_start(27'h0002000, 16'd4);
        send_ticks(3);
        send_start('0, 16'd1);
        wait_results(SETTLE_CYCLES);
    endtask

    task automatic run_frame_sequence();
        logic [FRAME_W-1:0] img;
        int                 pop;
        int                 scale;
        int                 passes;
        int                 eff;
        if ($urandom_range(0, 9) == 0)
            quiet = ~quiet;
        if ($urandom_range(0, 9) == 0)
            wait_results(0);
        if ($urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    send_start(FRAME_W'($urandom), REP_W'($urandom));
                    send_ticks($urandom_range(0, 15));
                end
                1: send_ticks($urandom_range(1, 8));
                default:
                begin
                    send_start(FRAME_W'($urandom), REP_W'($urandom_range(0, 40)));
                    send_ticks($urandom_range(0, 6));
                end
            endcase
        end
        else
        begin
            img = '0;
            if ($urandom_range(0, 7) == 0)
                img = FRAME_W'($urandom);
            else
                repeat ($urandom_range(1, 6)) img[$urandom_range(0, CELLS-1)] = 1'b1;
            if (img == '0)
                img = 27'h1;
            pop    = $countones(img);
            scale  = (pop < 4) ? pop + 3 : pop;
            passes = (pop > 8) ? 1 : $urandom_range(1, 3);
            eff    = (dwell_cfg == '0) ? 1 : dwell_cfg;
            send_start(img, REP_W'(passes * scale + $urandom_range(0, scale - 1)));
            send_ticks(passes * pop * eff + $urandom_range(0, 3));
        end
    endtask

    task automatic test_random_frames();
        logic [DWELL_W-1:0] dwell_set[6];
        int                 target;
        dwell_set = '{16'd1, 16'd2, 16'd3, 16'd0, 16'd1, 16'd2};
        dwell_set[4] = DWELL_W'($urandom_range(1, 4));
        foreach (dwell_set[p])
        begin
            write_dwell(dwell_set[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                run_frame_sequence();
            wait_results(SETTLE_CYCLES);
        end
        quiet = 1'b0;
    endtask

    initial
    begin : result_check
        lcsm_result_t got;
        lcsm_result_t want;
        int           stall;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
            got = m_tdata[13:0];
            if (expected_drive_q.size() == 0)
                note_mismatch($sformatf("unexpected item %h", got));
            else
            begin
                want = expected_drive_q.pop_front();
                if (got.layer_drive != want.layer_drive || got.column_drive != want.column_drive
                    || got.busy != want.busy || got.done != want.done)
                    note_mismatch($sformatf("layer %h/%h column %h/%h busy %b/%b done %b/%b",
                        want.layer_drive, got.layer_drive, want.column_drive, got.column_drive,
                        want.busy, got.busy, want.done, got.done));
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        quiet      = 1'b0;
        mismatches = 0;
        items_sent = 0;
        dwell_cfg  = DWELL_RESET;
        lit_image  = '0;
        stop_scan();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        test_reset_dwell();
        test_start_cases();
        test_dwell_extremes();
        test_random_frames();

        wait_results(SETTLE_CYCLES);
        if (mismatches == 0 && expected_drive_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lcsm_pkg.sv
rtl/lcsm_queue.sv
rtl/lcsm_front.sv
rtl/lcsm_back.sv
rtl/led_cube_scan_multiplexer_top.sv
dv/tb_led_cube_scan_multiplexer_top.sv
